>>> src/noc_pkg.sv
package noc_pkg;

  localparam int MaxObstacles = 16;
  localparam int SlotW        = $clog2(MaxObstacles);
  localparam int CountW       = 5;

  localparam logic signed [31:0] HalfFloor = 32'sd328;

  localparam logic [1:0] KIND_BOX = 2'd0;
  localparam logic [1:0] KIND_CYL = 2'd1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
    sx34 = {{2{v[31]}}, v};
  endfunction

  function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
                                                 input logic signed [33:0] lo,
                                                 input logic signed [33:0] hi);
    if (v < lo) clamp34 = lo;
    else if (v > hi) clamp34 = hi;
    else clamp34 = v;
  endfunction

  function automatic logic [31:0] mag34(input logic signed [33:0] v);
    logic signed [33:0] a;
    a = (v < 0) ? -v : v;
    mag34 = a[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [31:0] half_ext(input logic signed [31:0] size,
                                                  input logic signed [31:0] fb);
    logic signed [31:0] h;
    h = (size > 0) ? (size >>> 1) : fb;
    half_ext = (h > HalfFloor) ? h : HalfFloor;
  endfunction

endpackage

>>> src/nearest_obstacle_clearance_core.sv
// Load item: written into the table in the accept cycle, busy stays low.
// Query item: per slot, squares and a 33-step square root; sphere or cylinder slots
// add three 32-step divides unless at zero distance; S_DONE issues the result, and a
// zero count answers from idle. One 32x32 multiplier does squares and products; the
// root and divides use separate compares. out_valid is high for one cycle; no stall.
// Reset (rst_n low, synchronous) clears control state and obstacle_count.
module nearest_obstacle_clearance_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [3:0]         in_slot,
  input  logic [1:0]         in_geometry_kind,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic signed [31:0] in_size_x,
  input  logic signed [31:0] in_size_y,
  input  logic signed [31:0] in_size_z,
  input  logic signed [31:0] in_radius,
  input  logic signed [31:0] in_height,
  output logic               out_valid,
  output logic               out_detected,
  output logic [30:0]        out_clearance,
  output logic signed [31:0] out_near_x,
  output logic signed [31:0] out_near_y,
  output logic signed [31:0] out_near_z
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_SQ, S_SQRT, S_CLR, S_MUL, S_DINIT, S_DIV, S_DSTORE, S_UPD, S_DONE
  } state_t;

  localparam int N = noc_pkg::MaxObstacles;

  logic [1:0]         kind_mem [N];
  logic signed [31:0] cx_mem [N];
  logic signed [31:0] cy_mem [N];
  logic signed [31:0] cz_mem [N];
  logic signed [31:0] ex_mem [N];
  logic signed [31:0] ey_mem [N];
  logic signed [31:0] ez_mem [N];
  logic signed [31:0] rad_mem [N];
  logic signed [31:0] hgt_mem [N];

  state_t state_r;
  logic [noc_pkg::CountW-1:0] count_r, n_r;
  logic [noc_pkg::SlotW-1:0]  idx_r;
  logic [1:0]  ax_r;
  logic [5:0]  it_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [33:0] dx_r, dy_r, dz_r;
  logic signed [33:0] qx_r, qy_r, qz_r;
  logic        box_r;
  logic [31:0] r_r;
  logic [63:0] prod_r;
  logic [65:0] acc_r;
  logic [32:0] root_r;
  logic [35:0] rem_r;
  logic [31:0] mq_r;
  logic [32:0] clr_r, best_r;
  logic        found_r;
  logic signed [31:0] nx_r, ny_r, nz_r;

  logic [1:0]         k_cur;
  logic signed [31:0] cx_c, cy_c, cz_c, ex_c, ey_c, ez_c, rad_c, hgt_c;
  logic signed [33:0] cx34, cy34, cz34, bqx, bqy, bqz, hh34, czc;
  logic signed [33:0] dsel, csel, qnew;
  logic [31:0] mul_a, mul_b;
  logic [35:0] remsh, trial;
  logic [34:0] dt;
  logic        last;
  logic [4:0]  cnt_q;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    k_cur = kind_mem[idx_r];
    cx_c  = cx_mem[idx_r];
    cy_c  = cy_mem[idx_r];
    cz_c  = cz_mem[idx_r];
    ex_c  = ex_mem[idx_r];
    ey_c  = ey_mem[idx_r];
    ez_c  = ez_mem[idx_r];
    rad_c = rad_mem[idx_r];
    hgt_c = hgt_mem[idx_r];
    cx34  = noc_pkg::sx34(cx_c);
    cy34  = noc_pkg::sx34(cy_c);
    cz34  = noc_pkg::sx34(cz_c);
    bqx = noc_pkg::clamp34(noc_pkg::sx34(px_r), cx34 - noc_pkg::sx34(ex_c),
                           cx34 + noc_pkg::sx34(ex_c));
    bqy = noc_pkg::clamp34(noc_pkg::sx34(py_r), cy34 - noc_pkg::sx34(ey_c),
                           cy34 + noc_pkg::sx34(ey_c));
    bqz = noc_pkg::clamp34(noc_pkg::sx34(pz_r), cz34 - noc_pkg::sx34(ez_c),
                           cz34 + noc_pkg::sx34(ez_c));
    hh34 = (hgt_c > 0) ? (noc_pkg::sx34(hgt_c) >>> 1) : 34'sd0;
    czc  = noc_pkg::clamp34(noc_pkg::sx34(pz_r), cz34 - hh34, cz34 + hh34);

    case (ax_r)
      2'd0:    begin dsel = dx_r; csel = cx34; end
      2'd1:    begin dsel = dy_r; csel = cy34; end
      default: begin dsel = dz_r; csel = cz34; end
    endcase
    qnew = (dsel < 0) ? (csel + {2'b00, mq_r}) : (csel - {2'b00, mq_r});

    mul_a = noc_pkg::mag34(dsel);
    mul_b = (state_r == S_MUL) ? r_r : noc_pkg::mag34(dsel);

    remsh = {rem_r[33:0], acc_r[65:64]};
    trial = {1'b0, root_r, 2'b01};
    dt    = {rem_r[33:0], mq_r[31]};

    cnt_q = {1'b0, idx_r} + 5'd1;
    last  = (cnt_q == n_r);
  end

  always_ff @(posedge clk) begin
    if (start && !busy && in_action == noc_pkg::ACT_LOAD) begin
      kind_mem[in_slot] <= in_geometry_kind;
      cx_mem[in_slot]   <= in_coord_x;
      cy_mem[in_slot]   <= in_coord_y;
      cz_mem[in_slot]   <= in_coord_z;
      ex_mem[in_slot]   <= noc_pkg::half_ext(in_size_x, in_radius);
      ey_mem[in_slot]   <= noc_pkg::half_ext(in_size_y, in_radius);
      ez_mem[in_slot]   <= noc_pkg::half_ext(in_size_z, in_height >>> 1);
      rad_mem[in_slot]  <= in_radius;
      hgt_mem[in_slot]  <= in_height;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) count_r <= cfg_data;
      case (state_r)
        S_IDLE: begin
          if (start && in_action == noc_pkg::ACT_QUERY) begin
            px_r    <= in_coord_x;
            py_r    <= in_coord_y;
            pz_r    <= in_coord_z;
            idx_r   <= '0;
            found_r <= 1'b0;
            n_r <= (count_r > 5'(N)) ? 5'(N) : count_r;
            if (count_r == '0) begin
              out_valid     <= 1'b1;
              out_detected  <= 1'b0;
              out_clearance <= '0;
              out_near_x    <= '0;
              out_near_y    <= '0;
              out_near_z    <= '0;
            end else begin
              state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          acc_r <= '0;
          ax_r  <= 2'd0;
          r_r   <= (rad_c < 0) ? 32'd0 : rad_c;
          if (k_cur == noc_pkg::KIND_BOX) begin
            box_r <= 1'b1;
            qx_r  <= bqx;
            qy_r  <= bqy;
            qz_r  <= bqz;
            dx_r  <= noc_pkg::sx34(px_r) - bqx;
            dy_r  <= noc_pkg::sx34(py_r) - bqy;
            dz_r  <= noc_pkg::sx34(pz_r) - bqz;
          end else begin
            box_r <= 1'b0;
            qx_r  <= cx34;
            qy_r  <= cy34;
            qz_r  <= cz34;
            dx_r  <= cx34 - noc_pkg::sx34(px_r);
            dy_r  <= cy34 - noc_pkg::sx34(py_r);
            dz_r  <= (k_cur == noc_pkg::KIND_CYL) ? (cz34 - czc)
                                                 : (cz34 - noc_pkg::sx34(pz_r));
          end
          state_r <= S_SQ;
        end
        S_SQ: begin
          prod_r <= mul_a * mul_b;
          if (ax_r != 2'd0) acc_r <= acc_r + {2'b00, prod_r};
          if (ax_r == 2'd3) begin
            root_r  <= '0;
            rem_r   <= '0;
            it_r    <= '0;
            state_r <= S_SQRT;
          end else begin
            ax_r <= ax_r + 2'd1;
          end
        end
        S_SQRT: begin
          if (remsh >= trial) begin
            rem_r  <= remsh - trial;
            root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r  <= remsh;
            root_r <= {root_r[31:0], 1'b0};
          end
          acc_r <= acc_r << 2;
          it_r  <= it_r + 6'd1;
          if (it_r == 6'd32) state_r <= S_CLR;
        end
        S_CLR: begin
          ax_r <= 2'd0;
          if (box_r) begin
            clr_r   <= root_r;
            state_r <= S_UPD;
          end else begin
            clr_r <= (root_r > {1'b0, r_r}) ? (root_r - {1'b0, r_r}) : 33'd0;
            state_r <= (root_r == '0) ? S_UPD : S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_DINIT;
        end
        S_DINIT: begin
          rem_r   <= {5'd0, prod_r[62:32]};
          mq_r    <= prod_r[31:0];
          it_r    <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (dt >= {2'b00, root_r}) begin
            rem_r <= {1'b0, dt - {2'b00, root_r}};
            mq_r  <= {mq_r[30:0], 1'b1};
          end else begin
            rem_r <= {1'b0, dt};
            mq_r  <= {mq_r[30:0], 1'b0};
          end
          it_r <= it_r + 6'd1;
          if (it_r == 6'd31) state_r <= S_DSTORE;
        end
        S_DSTORE: begin
          case (ax_r)
            2'd0:    qx_r <= qnew;
            2'd1:    qy_r <= qnew;
            default: qz_r <= qnew;
          endcase
          if (ax_r == 2'd2) begin
            state_r <= S_UPD;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_UPD: begin
          if (!found_r || clr_r < best_r) begin
            found_r <= 1'b1;
            best_r  <= clr_r;
            nx_r    <= noc_pkg::sat32(qx_r);
            ny_r    <= noc_pkg::sat32(qy_r);
            nz_r    <= noc_pkg::sat32(qz_r);
          end
          if (last) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_FETCH;
          end
        end
        S_DONE: begin
          out_valid     <= 1'b1;
          out_detected  <= 1'b1;
          out_clearance <= best_r[32:31] != 2'b00 ? 31'h7FFFFFFF : best_r[30:0];
          out_near_x    <= nx_r;
          out_near_y    <= ny_r;
          out_near_z    <= nz_r;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> test/nearest_obstacle_clearance_core_tb.sv
module nearest_obstacle_clearance_core_tb;

  localparam logic [1:0] KindSphere = 2'd2;
  localparam logic [1:0] KindOdd    = 2'd3;
  localparam int         CycleLimit = 10_000_000;
  localparam logic signed [31:0] MaxS = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MinS = 32'sh80000000;
  localparam logic signed [31:0] OneM = 32'sd65536;

  typedef struct {
    logic              action;
    logic [3:0]        slot;
    logic [1:0]        kind;
    logic signed [31:0] x, y, z, sx, sy, sz, r, h;
  } obstacle_item_t;

  typedef struct {
    logic        detected;
    logic [30:0] clearance;
    logic [31:0] nx, ny, nz;
  } clearance_t;

  class clearance_board;
    logic [1:0] kind[noc_pkg::MaxObstacles];
    longint cx[noc_pkg::MaxObstacles], cy[noc_pkg::MaxObstacles];
    longint cz[noc_pkg::MaxObstacles];
    longint ex[noc_pkg::MaxObstacles], ey[noc_pkg::MaxObstacles];
    longint ez[noc_pkg::MaxObstacles];
    longint rad[noc_pkg::MaxObstacles], hgt[noc_pkg::MaxObstacles];
    int unsigned count;
    clearance_t pending[$];
    int errors;

    function longint floor_half(longint v);
      return (v >= 0) ? v / 2 : -((-v + 1) / 2);
    endfunction

    function longint half_ext(longint size, longint fb);
      longint hv;
      hv = floor_half(size > 0 ? size : fb);
      return (hv > 328) ? hv : 328;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint unsigned mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint unsigned root3(longint dx, longint dy, longint dz);
      logic [65:0] s;
      logic [67:0] rem;
      logic [33:0] rt;
      s = {2'b0, mag(dx) * mag(dx)} + {2'b0, mag(dy) * mag(dy)} + {2'b0, mag(dz) * mag(dz)};
      rem = 0;
      rt = 0;
      for (int i = 32; i >= 0; i--) begin
        rem = {rem[65:0], s[2*i+1 -: 2]};
        if (rem >= {32'b0, rt, 2'b01}) begin
          rem = rem - {32'b0, rt, 2'b01};
          rt = {rt[32:0], 1'b1};
        end else begin
          rt = {rt[32:0], 1'b0};
        end
      end
      return rt;
    endfunction

    function longint surf(longint c, longint d, longint r, longint unsigned dlen);
      longint unsigned q;
      if (dlen == 0) return c;
      q = (mag(d) * longint'(r)) / dlen;
      return (d < 0) ? c + longint'(q) : c - longint'(q);
    endfunction

    function logic [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function void note(obstacle_item_t it);
      longint px, py, pz, qx, qy, qz, dx, dy, dz, r, hh;
      longint unsigned clr, best, d;
      int unsigned n;
      clearance_t e;
      px = it.x; py = it.y; pz = it.z;
      if (it.action == noc_pkg::ACT_LOAD) begin
        kind[it.slot] = it.kind;
        cx[it.slot] = px; cy[it.slot] = py; cz[it.slot] = pz;
        ex[it.slot] = half_ext(it.sx, 2 * longint'(it.r));
        ey[it.slot] = half_ext(it.sy, 2 * longint'(it.r));
        ez[it.slot] = half_ext(it.sz, it.h);
        rad[it.slot] = it.r;
        hgt[it.slot] = it.h;
        return;
      end
      e = '{default: '0};
      best = 0;
      n = (count < noc_pkg::MaxObstacles) ? count : noc_pkg::MaxObstacles;
      for (int i = 0; i < n; i++) begin
        if (kind[i] == noc_pkg::KIND_BOX) begin
          qx = clamp(px, cx[i] - ex[i], cx[i] + ex[i]);
          qy = clamp(py, cy[i] - ey[i], cy[i] + ey[i]);
          qz = clamp(pz, cz[i] - ez[i], cz[i] + ez[i]);
          clr = root3(px - qx, py - qy, pz - qz);
        end else begin
          dx = cx[i] - px; dy = cy[i] - py; dz = cz[i] - pz;
          r = (rad[i] > 0) ? rad[i] : 0;
          if (kind[i] == noc_pkg::KIND_CYL) begin
            hh = floor_half(hgt[i] > 0 ? hgt[i] : 0);
            dz = cz[i] - clamp(pz, cz[i] - hh, cz[i] + hh);
          end
          d = root3(dx, dy, dz);
          clr = (d > r) ? d - r : 0;
          qx = surf(cx[i], dx, r, d);
          qy = surf(cy[i], dy, r, d);
          qz = surf(cz[i], dz, r, d);
        end
        if (!e.detected || clr < best) begin
          e.detected = 1'b1;
          best = clr;
          e.nx = sat(qx); e.ny = sat(qy); e.nz = sat(qz);
        end
      end
      e.clearance = (best > 64'h7FFFFFFF) ? 31'h7FFFFFFF : best[30:0];
      pending.push_back(e);
    endfunction

    function void check(clearance_t a);
      clearance_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.detected !== e.detected) begin
        $error("detected: expected %0d actual %0d", e.detected, a.detected); errors++;
      end
      if (a.clearance !== e.clearance) begin
        $error("clearance: expected %0d actual %0d", e.clearance, a.clearance); errors++;
      end
      if (a.nx !== e.nx) begin
        $error("near_x: expected %h actual %h", e.nx, a.nx); errors++;
      end
      if (a.ny !== e.ny) begin
        $error("near_y: expected %h actual %h", e.ny, a.ny); errors++;
      end
      if (a.nz !== e.nz) begin
        $error("near_z: expected %h actual %h", e.nz, a.nz); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic in_action = 1'b0;
  logic [3:0] in_slot = '0;
  logic [1:0] in_geometry_kind = '0;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic signed [31:0] in_size_x = '0, in_size_y = '0, in_size_z = '0;
  logic signed [31:0] in_radius = '0, in_height = '0;
  logic out_valid, out_detected;
  logic [30:0] out_clearance;
  logic signed [31:0] out_near_x, out_near_y, out_near_z;

  clearance_board board = new();
  int burst_left = 0;
  int cycles = 0;

  nearest_obstacle_clearance_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check('{out_detected, out_clearance, out_near_x, out_near_y, out_near_z});
  end

  task automatic send(obstacle_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_action <= it.action; in_slot <= it.slot; in_geometry_kind <= it.kind;
    in_coord_x <= it.x; in_coord_y <= it.y; in_coord_z <= it.z;
    in_size_x <= it.sx; in_size_y <= it.sy; in_size_z <= it.sz;
    in_radius <= it.r; in_height <= it.h;
    do @(posedge clk); while (busy);
    board.note(it);
  endtask

  task automatic set_count(int unsigned v);
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    board.count = v;
  endtask

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 9))
      0: return MaxS;
      1: return MinS;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 2621440)) - 32'sd1310720;
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_len();
    case ($urandom_range(0, 7))
      0: return rnd_val();
      1: return -$signed($urandom_range(0, 65536));
      default: return $urandom_range(0, 3 * 65536);
    endcase
  endfunction

  function automatic obstacle_item_t load(logic [3:0] s, logic [1:0] k,
      logic signed [31:0] x, y, z, sx, sy, sz, r, h);
    return '{noc_pkg::ACT_LOAD, s, k, x, y, z, sx, sy, sz, r, h};
  endfunction

  function automatic obstacle_item_t rnd_load(logic [3:0] s);
    return load(s, 2'($urandom_range(0, 3)), rnd_val(), rnd_val(), rnd_val(),
                rnd_len(), rnd_len(), rnd_len(), rnd_len(), rnd_len());
  endfunction

  function automatic obstacle_item_t query(logic signed [31:0] x, y, z);
    obstacle_item_t it;
    it = '{noc_pkg::ACT_QUERY, 4'($urandom), 2'($urandom), x, y, z, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    return it;
  endfunction

  function automatic obstacle_item_t rnd_query();
    int s;
    logic signed [31:0] p[3];
    s = $urandom_range(0, noc_pkg::MaxObstacles - 1);
    if ($urandom_range(0, 9) < 7) begin
      p[0] = 32'(board.cx[s] + ($signed($urandom_range(0, 524288)) - 262144));
      p[1] = 32'(board.cy[s] + ($signed($urandom_range(0, 524288)) - 262144));
      p[2] = 32'(board.cz[s] + ($signed($urandom_range(0, 524288)) - 262144));
    end else begin
      p[0] = rnd_val(); p[1] = rnd_val(); p[2] = rnd_val();
    end
    return query(p[0], p[1], p[2]);
  endfunction

  initial begin
    int unsigned counts[10] = '{1, 16, 31, 7, 0, 16, 3, 12, 2, 9};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_count(0);
    send(query(MaxS, MinS, 0));
    send(load(4'd0, noc_pkg::KIND_BOX, 0, 0, 0, 2 * OneM, 2 * OneM, 2 * OneM, 0, 0));
    send(load(4'd1, noc_pkg::KIND_BOX, 0, 0, 0, 0, -1, 0, OneM, 2 * OneM));
    send(load(4'd2, noc_pkg::KIND_BOX, 3 * OneM, 0, 0, MinS, 0, -5, -OneM, -OneM));
    send(load(4'd3, noc_pkg::KIND_CYL, 5 * OneM, 0, 0, 0, 0, 0, OneM / 2, OneM));
    send(load(4'd4, KindSphere, -5 * OneM, 0, 0, 0, 0, 0, OneM, 0));
    send(load(4'd5, KindOdd, 0, 7 * OneM, 0, 0, 0, 0, OneM / 3, 0));
    send(load(4'd6, KindSphere, 0, -7 * OneM, 0, 0, 0, 0, -OneM, 0));
    send(load(4'd7, noc_pkg::KIND_BOX, MaxS, MaxS, MaxS, MaxS, MaxS, MaxS, MaxS, MaxS));
    send(load(4'd8, KindSphere, MinS, MinS, MinS, 0, 0, 0, MaxS, MinS));
    send(load(4'd9, noc_pkg::KIND_CYL, MaxS, MinS, MaxS, 0, 0, 0, MaxS, MinS));
    for (int s = 10; s < noc_pkg::MaxObstacles; s++) send(rnd_load(4'(s)));
    set_count(5);
    send(query(-5 * OneM, 0, 0));
    send(query(5 * OneM, 0, 3 * OneM));
    set_count(16);
    send(query(0, 0, 0));
    send(query(MinS, MinS, MinS));
    send(query(MaxS, MaxS, MaxS));
    set_count(31);
    send(query(MaxS, MinS, MaxS));

    foreach (counts[ph]) begin
      set_count(ph == 9 ? $urandom_range(0, 31) : counts[ph]);
      repeat (56) begin
        if ($urandom_range(0, 99) < 35) send(rnd_load(4'($urandom_range(0, 15))));
        else send(rnd_query());
      end
    end

    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
